// ===== hdl/dop_pkg.sv =====
// Shared types and constants for the derivative order parser.
// Depends on nothing; every other file of the block but dop_if imports it.
package dop_pkg;

    localparam logic [7:0]  MAX_ORDER     = 8'd128;
    localparam logic [15:0] ADVANCE_LIMIT = 16'hFFFF;

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] U8_LEAD2  = 8'hC2;
    localparam logic [7:0] U8_LEAD3  = 8'hE2;
    localparam logic [7:0] U8_MID3   = 8'h81;
    localparam logic [7:0] U8_SUP0   = 8'hB0;
    localparam logic [7:0] U8_SUP1   = 8'hB9;
    localparam logic [7:0] U8_SUP2   = 8'hB2;
    localparam logic [7:0] U8_SUP3   = 8'hB3;
    localparam logic [7:0] U8_SUP4   = 8'hB4;
    localparam logic [7:0] U8_SUP9   = 8'hB9;

    typedef logic [1:0] t_status;
    localparam t_status ST_NONE = 2'd0;
    localparam t_status ST_OK   = 2'd1;
    localparam t_status ST_BAD  = 2'd2;

    typedef struct packed {
        logic       is_ws;
        logic       is_caret;
        logic       is_lbrace;
        logic       is_rbrace;
        logic       is_dec;
        logic [3:0] dec_val;
        logic       is_lead2;
        logic       is_lead3;
        logic       is_mid3;
        logic       is_sup2;
        logic [3:0] sup2_val;
        logic       is_sup3;
        logic [3:0] sup3_val;
    } t_byte_class;

endpackage

// ===== hdl/dop_if.sv =====
// Handshake channels of the derivative order parser: byte input and result output.
// Depends on nothing.
interface dop_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       start_req;
    modport source (output valid, output text_byte, output start_req, input ready);
    modport sink   (input valid, input text_byte, input start_req, output ready);
endinterface

interface dop_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  order_value;
    logic [15:0] advance;
    modport source (output valid, output status, output order_value, output advance,
                    input ready);
    modport sink   (input valid, input status, input order_value, input advance,
                    output ready);
endinterface

// ===== hdl/dop_byte_class.sv =====
// Byte decoder: classifies one text byte for the parser state machine.
// Depends on dop_pkg.
module dop_byte_class (
    input  logic [7:0]          i_text_byte,
    output dop_pkg::t_byte_class o_cls
);
    import dop_pkg::*;

    logic [7:0] w_dec_off;
    logic [7:0] w_sup_off;

    assign w_dec_off = i_text_byte - CH_ZERO;
    assign w_sup_off = i_text_byte - U8_SUP0;

    always_comb begin
        o_cls.is_ws     = (i_text_byte == CH_SPACE) ||
                          ((i_text_byte >= CH_TAB) && (i_text_byte <= CH_CR));
        o_cls.is_caret  = (i_text_byte == CH_CARET);
        o_cls.is_lbrace = (i_text_byte == CH_LBRACE);
        o_cls.is_rbrace = (i_text_byte == CH_RBRACE);
        o_cls.is_dec    = (i_text_byte >= CH_ZERO) && (i_text_byte <= CH_NINE);
        o_cls.dec_val   = w_dec_off[3:0];
        o_cls.is_lead2  = (i_text_byte == U8_LEAD2);
        o_cls.is_lead3  = (i_text_byte == U8_LEAD3);
        o_cls.is_mid3   = (i_text_byte == U8_MID3);
        o_cls.is_sup2   = (i_text_byte == U8_SUP1) || (i_text_byte == U8_SUP2) ||
                          (i_text_byte == U8_SUP3);
        o_cls.sup2_val  = (i_text_byte == U8_SUP1) ? 4'd1 : w_sup_off[3:0];
        o_cls.is_sup3   = (i_text_byte == U8_SUP0) ||
                          ((i_text_byte >= U8_SUP4) && (i_text_byte <= U8_SUP9));
        o_cls.sup3_val  = w_sup_off[3:0];
    end

endmodule

// ===== hdl/dop_parse_core.sv =====
// Parser state machine with its result register and the channel handshakes.
// Depends on dop_pkg, dop_if and the decoded byte from dop_byte_class.
module dop_parse_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dop_pkg::t_byte_class i_cls,
    dop_in_if.sink               i_byte_chan,
    dop_out_if.source            o_result_chan
);
    import dop_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_LEAD, PH_CWS1, PH_CWS2, PH_RDEC,
        PH_SLEAD, PH_S2, PH_S3A, PH_S3B, PH_CLOSE
    } t_phase;

    t_phase      r_phase, n_phase, w_ph;
    logic        r_caret, n_caret, w_caret;
    logic        r_brace, n_brace, w_brace;
    logic        r_seen, n_seen, w_seen;
    logic [7:0]  r_acc, n_acc, w_acc;
    logic [15:0] r_cnt, n_cnt, w_cnt;
    logic        r_over, n_over, w_over;

    logic        r_out_valid;
    t_status     r_status;
    logic [7:0]  r_order;
    logic [15:0] r_advance;

    logic        w_accept;
    logic        w_emit;
    t_status     w_est;
    logic        w_fin, w_bad;
    logic        w_do_slead, w_do_rdec, w_do_endrun;
    logic        w_dig_go;
    logic [3:0]  w_dig_val;
    logic [1:0]  w_cons;
    logic [11:0] w_prod;
    logic [16:0] w_sum;

    assign i_byte_chan.ready = !r_out_valid || o_result_chan.ready;
    assign w_accept          = i_byte_chan.valid && i_byte_chan.ready;

    always_comb begin
        w_ph    = i_byte_chan.start_req ? PH_LEAD : r_phase;
        w_caret = i_byte_chan.start_req ? 1'b0 : r_caret;
        w_brace = i_byte_chan.start_req ? 1'b0 : r_brace;
        w_seen  = i_byte_chan.start_req ? 1'b0 : r_seen;
        w_acc   = i_byte_chan.start_req ? 8'd0 : r_acc;
        w_cnt   = i_byte_chan.start_req ? 16'd0 : r_cnt;
        w_over  = i_byte_chan.start_req ? 1'b0 : r_over;

        n_phase     = w_ph;
        n_caret     = w_caret;
        n_brace     = w_brace;
        n_seen      = w_seen;
        n_acc       = w_acc;
        w_cons      = 2'd0;
        w_fin       = 1'b0;
        w_bad       = 1'b0;
        w_do_slead  = 1'b0;
        w_do_rdec   = 1'b0;
        w_do_endrun = 1'b0;
        w_dig_go    = 1'b0;
        w_dig_val   = 4'd0;

        case (w_ph)
            PH_LEAD: begin
                if (i_cls.is_ws) begin
                    w_cons = 2'd1;
                end else if (i_cls.is_caret) begin
                    n_caret = 1'b1;
                    w_cons  = 2'd1;
                    n_phase = PH_CWS1;
                end else begin
                    w_do_slead = 1'b1;
                end
            end
            PH_CWS1: begin
                if (i_cls.is_ws) begin
                    w_cons = 2'd1;
                end else if (i_cls.is_lbrace) begin
                    n_brace = 1'b1;
                    w_cons  = 2'd1;
                    n_phase = PH_CWS2;
                end else begin
                    w_do_rdec = 1'b1;
                end
            end
            PH_CWS2: begin
                if (i_cls.is_ws) begin
                    w_cons = 2'd1;
                end else begin
                    w_do_rdec = 1'b1;
                end
            end
            PH_RDEC:  w_do_rdec = 1'b1;
            PH_SLEAD: w_do_slead = 1'b1;
            PH_S2: begin
                if (i_cls.is_sup2) begin
                    w_dig_go  = 1'b1;
                    w_dig_val = i_cls.sup2_val;
                    w_cons    = 2'd2;
                    n_phase   = PH_SLEAD;
                end else begin
                    w_fin = 1'b1;
                end
            end
            PH_S3A: begin
                if (i_cls.is_mid3) begin
                    n_phase = PH_S3B;
                end else begin
                    w_fin = 1'b1;
                end
            end
            PH_S3B: begin
                if (i_cls.is_sup3) begin
                    w_dig_go  = 1'b1;
                    w_dig_val = i_cls.sup3_val;
                    w_cons    = 2'd3;
                    n_phase   = PH_SLEAD;
                end else begin
                    w_fin = 1'b1;
                end
            end
            PH_CLOSE: w_do_endrun = 1'b1;
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (w_do_slead) begin
            if (i_cls.is_lead2) begin
                n_phase = PH_S2;
            end else if (i_cls.is_lead3) begin
                n_phase = PH_S3A;
            end else begin
                w_fin = 1'b1;
            end
        end

        if (w_do_rdec) begin
            if (i_cls.is_dec) begin
                w_dig_go  = 1'b1;
                w_dig_val = i_cls.dec_val;
                w_cons    = 2'd1;
                n_phase   = PH_RDEC;
            end else begin
                w_do_endrun = 1'b1;
            end
        end

        if (w_do_endrun) begin
            if (w_brace) begin
                if (i_cls.is_ws) begin
                    w_cons  = 2'd1;
                    n_phase = PH_CLOSE;
                end else if (i_cls.is_rbrace) begin
                    w_cons = 2'd1;
                    w_fin  = 1'b1;
                end else begin
                    w_bad = 1'b1;
                end
            end else begin
                w_fin = 1'b1;
            end
        end

        w_prod = ({4'd0, w_acc} * 12'd10) + {8'd0, w_dig_val};
        if (w_dig_go) begin
            if (w_prod > {4'd0, MAX_ORDER}) begin
                w_bad  = 1'b1;
                w_cons = 2'd0;
            end else begin
                n_acc  = w_prod[7:0];
                n_seen = 1'b1;
            end
        end

        w_sum = {1'b0, w_cnt} + {15'd0, w_cons};
        if (w_sum > {1'b0, ADVANCE_LIMIT}) begin
            n_over = 1'b1;
            n_cnt  = ADVANCE_LIMIT;
        end else begin
            n_over = w_over;
            n_cnt  = w_sum[15:0];
        end

        w_emit = w_fin || w_bad;
        if (w_bad) begin
            w_est = ST_BAD;
        end else if (!n_seen) begin
            w_est = n_caret ? ST_BAD : ST_NONE;
        end else if ((n_acc == 8'd0) || n_over) begin
            w_est = ST_BAD;
        end else begin
            w_est = ST_OK;
        end
        if (w_emit) begin
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_caret     <= 1'b0;
            r_brace     <= 1'b0;
            r_seen      <= 1'b0;
            r_acc       <= 8'd0;
            r_cnt       <= 16'd0;
            r_over      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_caret <= n_caret;
                r_brace <= n_brace;
                r_seen  <= n_seen;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
                r_over  <= n_over;
            end
            if (w_accept && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result_chan.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_status  <= w_est;
            r_order   <= (w_est == ST_OK) ? n_acc : 8'd0;
            r_advance <= (w_est == ST_OK) ? n_cnt : 16'd0;
        end
    end

    assign o_result_chan.valid       = r_out_valid;
    assign o_result_chan.status      = r_status;
    assign o_result_chan.order_value = r_order;
    assign o_result_chan.advance     = r_advance;

endmodule

// ===== hdl/derivative_order_parser_top.sv =====
// Derivative order parser top level: byte decoder feeding the parser core.
// A result is registered and appears in the cycle after the byte that decides the parse.
// Throughput: one byte per cycle; a byte is taken whenever the result register
// is empty or is being read in the same cycle.
// Reset (synchronous, active low) puts the parser idle with no result pending.
// Depends on dop_pkg, dop_if, dop_byte_class and dop_parse_core.
module derivative_order_parser_top (
    input logic       i_clk,
    input logic       i_rst_n,
    dop_in_if.sink    i_byte_chan,
    dop_out_if.source o_result_chan
);
    import dop_pkg::*;

    t_byte_class w_cls;

    dop_byte_class u_byte_class (
        .i_text_byte (i_byte_chan.text_byte),
        .o_cls       (w_cls)
    );

    dop_parse_core u_parse_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cls         (w_cls),
        .i_byte_chan   (i_byte_chan),
        .o_result_chan (o_result_chan)
    );

endmodule
